### rtl/core/ova_pkg.sv
package ova_pkg;

    localparam int VOICES      = 8;
    localparam int SLOT_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W       = $clog2(VOICES + 1);

    localparam int TIME_W      = 32;
    localparam int HANDLE_W    = 32;
    localparam int SAMPLE_W    = 8;
    localparam int THR_W       = 8;
    localparam int OUT_SLOT_W  = 3;
    localparam int OUT_CNT_W   = 4;

    localparam logic [THR_W-1:0] THR_RESET = 8'd8;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // start time in the upper half so that one compare orders by (start, handle)
    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [HANDLE_W-1:0] handle;
    } t_voice;

endpackage

### rtl/core/oldest_voice_allocator.sv
// A trigger with a free voice goes from ST_IDLE straight to ST_DONE; when every voice is
// active, ST_SCAN first reads each voice in turn (one memory read per voice) and the oldest
// is stolen. ST_DONE registers the result once the output register is free.
// One trigger in flight at a time, a finished result may wait in the output register.
// Reset (i_rst_n low, synchronous): fill count 0, handle counter 1, threshold 8;
// the voice memory is not cleared, entries at or above the fill count are never read.
module oldest_voice_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ova_pkg::THR_W-1:0]          i_cfg_wdata,    // sd_threshold
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] when_samples, [39:32] sample_index
    input  logic [ova_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] voice_slot, [34:3] voice_handle, [35] stolen, [36] uses_sd,
    // [40:37] active_count, [47:41] zero
    output logic [ova_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    localparam int RES_W = ova_pkg::OUT_CNT_W + 2 + ova_pkg::HANDLE_W + ova_pkg::OUT_SLOT_W;

    t_state                          r_state, n_state;
    logic [ova_pkg::CNT_W-1:0]       r_count, n_count;
    logic [ova_pkg::HANDLE_W-1:0]    r_next_handle, n_next_handle;
    logic [ova_pkg::THR_W-1:0]       r_thr;
    logic [ova_pkg::SLOT_W-1:0]      r_idx, n_idx;
    logic [ova_pkg::SLOT_W-1:0]      r_slot, n_slot;
    ova_pkg::t_voice                 r_best, n_best;
    logic [ova_pkg::TIME_W-1:0]      r_when, n_when;
    logic                            r_stolen, n_stolen;
    logic                            r_uses_sd, n_uses_sd;
    logic                            r_m_valid, n_m_valid;
    logic [ova_pkg::OUT_TDATA_W-1:0] r_m_data, n_m_data;

    logic                            in_xfer;
    logic [ova_pkg::TIME_W-1:0]      in_when;
    logic [ova_pkg::SAMPLE_W-1:0]    in_sidx;
    logic                            ram_we;
    logic [ova_pkg::SLOT_W-1:0]      ram_waddr;
    logic [ova_pkg::SLOT_W-1:0]      ram_raddr;
    ova_pkg::t_voice                 ram_wdata;
    ova_pkg::t_voice                 ram_rdata;
    logic                            better;
    logic [RES_W-1:0]                res;

    assign in_when       = s_axis_tdata[ova_pkg::TIME_W-1:0];
    assign in_sidx       = s_axis_tdata[ova_pkg::TIME_W +: ova_pkg::SAMPLE_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    ova_voice_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // first entry seeds the minimum; strict compare keeps the lower index on a full tie
    assign better = (r_idx == '0) || (ram_rdata < r_best);

    assign res = {ova_pkg::OUT_CNT_W'(r_count), r_uses_sd, r_stolen, r_next_handle,
                  ova_pkg::OUT_SLOT_W'(r_slot)};

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_next_handle = r_next_handle;
        n_idx         = r_idx;
        n_slot        = r_slot;
        n_best        = r_best;
        n_when        = r_when;
        n_stolen      = r_stolen;
        n_uses_sd     = r_uses_sd;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_data      = r_m_data;
        ram_we        = 1'b0;
        ram_waddr     = r_slot;
        ram_raddr     = '0;
        ram_wdata     = '{start: r_when, handle: r_next_handle};
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_when    = in_when;
                    n_uses_sd = (in_sidx >= r_thr);
                    if (r_count < ova_pkg::CNT_W'(ova_pkg::VOICES)) begin
                        // voices only fill up, so the lowest free one is the fill count
                        ram_we    = 1'b1;
                        ram_waddr = r_count[ova_pkg::SLOT_W-1:0];
                        ram_wdata = '{start: in_when, handle: r_next_handle};
                        n_slot    = r_count[ova_pkg::SLOT_W-1:0];
                        n_stolen  = 1'b0;
                        n_count   = r_count + ova_pkg::CNT_W'(1);
                        n_state   = ST_DONE;
                    end else begin
                        ram_raddr = '0;
                        n_idx     = '0;
                        n_stolen  = 1'b1;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (better) begin
                    n_best = ram_rdata;
                    n_slot = r_idx;
                end
                if (r_idx == ova_pkg::SLOT_W'(ova_pkg::VOICES - 1)) begin
                    ram_we    = 1'b1;
                    ram_waddr = better ? r_idx : r_slot;
                    n_state   = ST_DONE;
                end else begin
                    ram_raddr = r_idx + ova_pkg::SLOT_W'(1);
                    n_idx     = r_idx + ova_pkg::SLOT_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid     = 1'b1;
                    n_m_data      = ova_pkg::OUT_TDATA_W'(res);
                    n_next_handle = (r_next_handle == '1) ? ova_pkg::HANDLE_W'(1)
                                                          : r_next_handle + ova_pkg::HANDLE_W'(1);
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_next_handle <= ova_pkg::HANDLE_W'(1);
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_next_handle <= n_next_handle;
            r_m_valid     <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ova_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_best    <= n_best;
        r_when    <= n_when;
        r_stolen  <= n_stolen;
        r_uses_sd <= n_uses_sd;
        r_m_data  <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ova_pkg::CNT_W'(ova_pkg::VOICES))
        else $error("fill count beyond voice count");

    a_handle_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_handle != '0)
        else $error("handle counter reached zero");

    a_steal_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count == ova_pkg::CNT_W'(ova_pkg::VOICES)))
        else $error("voice scan started with a free voice");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_idx == ova_pkg::SLOT_W'(ova_pkg::VOICES - 1))
        |=> (r_state == ST_DONE))
        else $error("scan did not finish after last voice");

endmodule

### rtl/core/ova_voice_ram.sv
module ova_voice_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ova_pkg::SLOT_W-1:0] i_waddr,
    input  ova_pkg::t_voice            i_wdata,
    input  logic [ova_pkg::SLOT_W-1:0] i_raddr,
    output ova_pkg::t_voice            o_rdata
);

    ova_pkg::t_voice r_mem [ova_pkg::VOICES];
    ova_pkg::t_voice r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
